/* src/assert_macros.svh */
// Assertion macros shared by the decompressor RTL.
// Bodies use the clock and reset names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/lzhd_pkg.sv */
// Shared types, constants and the length-code table of the decompressor.
// No dependencies.
package lzhd_pkg;

   localparam int unsigned MAX_WINDOW_BITS = 15;
   localparam int unsigned OUT_LIMIT       = 17;
   localparam int unsigned TMP_DEPTH       = 17;

   localparam logic [3:0] FLUSH_CODE = 4'd15;

   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   localparam logic [1:0] REG_WINDOW_BITS  = 2'd0;
   localparam logic [1:0] REG_LITERAL_BITS = 2'd1;
   localparam logic [1:0] REG_MIN_MATCH    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD,
      ST_CAP,
      ST_WR,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      TOK_NONE,
      TOK_LIT,
      TOK_MATCH,
      TOK_FLUSH
   } tok_type;

   typedef struct packed {
      logic load_byte;
      logic preload;
      logic lit_take;
      logic match_take;
      logic flush_take;
      logic rd_issue;
      logic rd_capture;
      logic wr_emit;
      logic fin_emit;
   } cmd_type;

   typedef struct packed {
      tok_type tok;
      logic    can_emit;
      logic    cnt_last;
      logic    pend_valid;
      logic    match_empty;
   } status_type;

   // {extra bits, code} for the seven bits after a leading one
   function automatic logic [6:0] length_code(input logic [6:0] idx);
      logic [6:0] e;
      if (idx >= 7'd64)      e = 7'h11;
      else if (idx >= 7'd48) e = 7'h33;
      else if (idx >= 7'd44) e = 7'h57;
      else if (idx == 7'd43) e = 7'h7F;
      else if (idx == 7'd42) e = 7'h7C;
      else if (idx >= 7'd40) e = 7'h69;
      else if (idx >= 7'd32) e = 7'h44;
      else if (idx >= 7'd28) e = 7'h5D;
      else if (idx >= 7'd24) e = 7'h56;
      else if (idx >= 7'd22) e = 7'h68;
      else if (idx == 7'd21) e = 7'h7B;
      else if (idx == 7'd20) e = 7'h7A;
      else if (idx >= 7'd16) e = 7'h55;
      else                   e = 7'h32;
      return e;
   endfunction

endpackage

/* src/lzhd_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
// Depends on lzhd_pkg for the address width.
interface lzhd_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     opcode;
   logic [7:0]                               data_byte;
   logic [lzhd_pkg::MAX_WINDOW_BITS-1:0]     dict_addr;
   modport source(output valid, opcode, data_byte, dict_addr, input ready);
   modport sink(input valid, opcode, data_byte, dict_addr, output ready);
endinterface

interface lzhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   modport source(output valid, out_byte, last, input ready);
   modport sink(input valid, out_byte, last, output ready);
endinterface

/* src/lzss_huffman_length_decompressor.sv */
// LZSS decompressor with prefix-coded match lengths.
// req_ch (sink): opcode 0 feeds one compressed byte, opcode 1 preloads
//   data_byte into the window at dict_addr. Accepted when valid and ready.
// rsp_ch (source): one decompressed byte per transaction; last marks the
//   final byte caused by an input transaction. A byte that completes no
//   token and every preload cause no result.
// One input transaction is worked on at a time. A preload writes the window
// and leaves the block idle. A compressed byte is loaded, then each literal
// or flush token is taken, and each match does len window reads through the
// single read port of the window RAM, then len writes.
// The byte ends in state ST_FIN and yields up to 17 results.
// Results go through a holding byte and an output register, so the first
// byte of a transaction leaves as soon as the second is decoded.
// A stalled receiver holds the decoder whenever the output register is full.
// Reset (synchronous, active high) empties the bit buffer, zeroes the write
// position and sets window_bits 10, literal_bits 8, min_match 2; window
// contents stay undefined until written. Registers sit on an APB-style
// port at byte addresses 0, 4 and 8; write them only while idle.
`include "assert_macros.svh"

module lzss_huffman_length_decompressor (
   input  logic              clock,
   input  logic              reset,
   lzhd_req_if.sink          req_ch,
   lzhd_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import lzhd_pkg::*;

   logic [3:0] wb_ff, wb_in;
   logic [3:0] lb_ff, lb_in;
   logic [1:0] mm_ff, mm_in;
   logic [3:0] wb_use, lb_use;
   logic       csr_write;
   cmd_type    cmd;
   status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      wb_in = wb_ff;
      lb_in = lb_ff;
      mm_in = mm_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_WINDOW_BITS:  wb_in = pwdata[3:0];
            REG_LITERAL_BITS: lb_in = pwdata[3:0];
            REG_MIN_MATCH:    mm_in = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= 4'd10;
         lb_ff <= 4'd8;
         mm_ff <= 2'd2;
      end else begin
         wb_ff <= wb_in;
         lb_ff <= lb_in;
         mm_ff <= mm_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_WINDOW_BITS:  prdata = {28'd0, wb_ff};
         REG_LITERAL_BITS: prdata = {28'd0, lb_ff};
         REG_MIN_MATCH:    prdata = {30'd0, mm_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // clamp to the supported ranges
   assign wb_use = (wb_ff < 4'd8) ? 4'd8 : wb_ff;
   assign lb_use = (lb_ff < 4'd5) ? 4'd5 : ((lb_ff > 4'd8) ? 4'd8 : lb_ff);

   lzhd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   lzhd_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .wb           (wb_use),
      .lb           (lb_use),
      .mm           (mm_ff),
      .data_byte    (req_ch.data_byte),
      .dict_addr    (req_ch.dict_addr),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_out_byte (rsp_ch.out_byte),
      .rsp_last     (rsp_ch.last)
   );

   `ASSERT_IMP(a_one_token, 1'b1, $onehot0({cmd.lit_take, cmd.match_take, cmd.flush_take}))
   `ASSERT_NXT(a_busy_after_byte, cmd.load_byte, !req_ch.ready)
   `ASSERT_NXT(a_idle_after_preload, cmd.preload, req_ch.ready)
   `ASSERT_IMP(a_emit_has_room, cmd.lit_take || cmd.wr_emit || cmd.fin_emit, !rsp_ch.valid || rsp_ch.ready)

endmodule

/* src/lzhd_ctrl.sv */
// Sequencer of the decompressor: accepts transactions and steps the datapath
// through tokens, match reads and match writes. Depends on lzhd_pkg.
module lzhd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_ready,
   input  lzhd_pkg::status_type   status,
   output lzhd_pkg::cmd_type      cmd
);
   import lzhd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_PRELOAD) begin
                  cmd.preload = 1'b1;
               end else begin
                  cmd.load_byte = 1'b1;
                  state_in      = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            case (status.tok)
               TOK_LIT: begin
                  if (status.can_emit) cmd.lit_take = 1'b1;
               end
               TOK_FLUSH: cmd.flush_take = 1'b1;
               TOK_MATCH: begin
                  cmd.match_take = 1'b1;
                  // a zero-length match only drops its bits
                  state_in       = status.match_empty ? ST_DECODE : ST_RD;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_CAP;
         end
         ST_CAP: begin
            cmd.rd_capture = 1'b1;
            state_in       = status.cnt_last ? ST_WR : ST_RD;
         end
         ST_WR: begin
            if (status.can_emit) begin
               cmd.wr_emit = 1'b1;
               if (status.cnt_last) state_in = ST_DECODE;
            end
         end
         ST_FIN: begin
            // hold the last byte back until we know it ends the transaction
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.can_emit) begin
               cmd.fin_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* src/lzhd_dpath.sv */
// Datapath: bit buffer, token decode, ring window memory, match buffer and
// result staging. Depends on lzhd_pkg.
module lzhd_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [3:0]                            wb,
   input  logic [3:0]                            lb,
   input  logic [1:0]                            mm,
   input  logic [7:0]                            data_byte,
   input  logic [lzhd_pkg::MAX_WINDOW_BITS-1:0]  dict_addr,
   input  lzhd_pkg::cmd_type                     cmd,
   output lzhd_pkg::status_type                  status,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_last
);
   import lzhd_pkg::*;

   localparam int unsigned AW = MAX_WINDOW_BITS;

   logic [31:0]   bs_ff, bs_in;
   logic [5:0]    bc_ff, bc_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [4:0]    n_ff, n_in;
   logic [AW-1:0] off_ff;
   logic [4:0]    len_ff;
   logic [4:0]    cnt_ff, cnt_in;
   logic [7:0]    tmp_ff [TMP_DEPTH];
   logic [7:0]    window_mem [2**AW];
   logic [7:0]    mem_rd_ff;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;

   logic [AW-1:0] wmask, pos, rd_addr, waddr, off;
   logic [3:0]    need;
   logic [7:0]    lit_val, emit_byte, wdata;
   logic [6:0]    lcode;
   logic [3:0]    code, used;
   logic [31:0]   rest2;
   logic [5:0]    left;
   logic [4:0]    len;
   logic          lit_ok, match_ok, emit, mem_we;

   assign wmask = AW'((16'd1 << wb) - 16'd1);
   assign pos   = wpos_ff & wmask;

   // token decode
   always_comb begin
      need    = 4'd1 + lb;
      lit_val = bs_ff[30:23] >> (4'd8 - lb);
      lit_ok  = (bc_ff >= {2'b0, need}) && (n_ff < 5'(OUT_LIMIT));
      lcode   = length_code(bs_ff[29:23]);
      if (!bs_ff[30]) begin
         code = 4'd0;
         used = 4'd1;
      end else begin
         code = lcode[3:0];
         used = 4'd1 + {1'b0, lcode[6:4]};
      end
      rest2    = bs_ff << (4'd1 + used);
      left     = bc_ff - 6'd1 - {2'b0, used};
      len      = 5'(code) + 5'(mm);
      off      = AW'(rest2[31:32-AW] >> (4'(AW) - wb));
      match_ok = (left >= {2'b0, wb}) && ((6'(n_ff) + 6'(len)) <= 6'(OUT_LIMIT));
      if (bc_ff == 6'd0)         status.tok = TOK_NONE;
      else if (bs_ff[31])        status.tok = lit_ok ? TOK_LIT : TOK_NONE;
      else if (bc_ff <= 6'd8)    status.tok = TOK_NONE;
      else if (code == FLUSH_CODE) status.tok = TOK_FLUSH;
      else if (match_ok)         status.tok = TOK_MATCH;
      else                       status.tok = TOK_NONE;
      status.can_emit    = !out_valid_ff || rsp_ready;
      status.cnt_last    = (cnt_ff == len_ff - 5'd1);
      status.pend_valid  = pend_valid_ff;
      status.match_empty = (len == 5'd0);
   end

   assign emit      = cmd.lit_take || cmd.wr_emit;
   assign emit_byte = cmd.lit_take ? lit_val : tmp_ff[cnt_ff];
   assign mem_we    = cmd.preload || emit;
   assign waddr     = cmd.preload ? (dict_addr & wmask) : pos;
   assign wdata     = cmd.preload ? data_byte : emit_byte;
   assign rd_addr   = (off_ff + AW'(cnt_ff)) & wmask;

   always_comb begin
      bs_in         = bs_ff;
      bc_in         = bc_ff;
      wpos_in       = wpos_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (cmd.load_byte) begin
         n_in = 5'd0;
         // drop the byte if the buffer cannot take it
         if (bc_ff <= 6'd24) begin
            bs_in = bs_ff | (32'(data_byte) << (6'd24 - bc_ff));
            bc_in = bc_ff + 6'd8;
         end
      end
      if (cmd.lit_take) begin
         bs_in = bs_ff << need;
         bc_in = bc_ff - {2'b0, need};
      end
      if (cmd.flush_take) begin
         bs_in = rest2 << left[2:0];
         bc_in = {left[5:3], 3'b000};
      end
      if (cmd.match_take) begin
         bs_in  = rest2 << wb;
         bc_in  = left - {2'b0, wb};
         cnt_in = 5'd0;
      end
      if (cmd.rd_capture || cmd.wr_emit) begin
         cnt_in = status.cnt_last ? 5'd0 : cnt_ff + 5'd1;
      end
      if (emit) begin
         wpos_in       = (pos + AW'(1)) & wmask;
         n_in          = n_ff + 5'd1;
         pend_valid_in = 1'b1;
         pend_byte_in  = emit_byte;
      end
      if ((emit && pend_valid_ff) || cmd.fin_emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = pend_byte_ff;
         out_last_in  = cmd.fin_emit;
      end
      if (cmd.fin_emit) pend_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff         <= '0;
         bc_ff         <= '0;
         wpos_ff       <= '0;
         n_ff          <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         bs_ff         <= bs_in;
         bc_ff         <= bc_in;
         wpos_ff       <= wpos_in;
         n_ff          <= n_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      if (cmd.match_take) begin
         off_ff <= off;
         len_ff <= len;
      end
      if (cmd.rd_capture) tmp_ff[cnt_ff] <= mem_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) window_mem[waddr] <= wdata;
      if (cmd.rd_issue) mem_rd_ff <= window_mem[rd_addr];
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

endmodule
